[rtl/core/conv3_pkg.sv]
// Shared types and constants for the 3x3 selectable-kernel filter.
`default_nettype none

package conv3_pkg;

    localparam int CFG_W    = 11;
    localparam int CFG_IW   = 2;
    localparam int PIX_W    = 8;
    localparam int OUT_W    = 9;
    localparam int SUM_W    = 13;
    localparam int OQ_DEPTH = 4;
    localparam int OQ_AW    = 2;

    localparam logic [CFG_IW-1:0] REG_KERNEL_MODE  = 2'd0;
    localparam logic [CFG_IW-1:0] REG_FRAME_WIDTH  = 2'd1;
    localparam logic [CFG_IW-1:0] REG_FRAME_HEIGHT = 2'd2;

    localparam logic [CFG_W-1:0] SIZE_MIN   = 11'd3;
    localparam logic [CFG_W-1:0] SIZE_RESET = 11'd1024;

    // floor(x / 9) == (x * DIV9_MUL) >> 16 for 0 <= x <= 2295
    localparam logic [25:0] DIV9_MUL = 26'd7282;

    typedef enum logic [1:0] {
        MODE_BOX     = 2'd0,
        MODE_GAUSS   = 2'd1,
        MODE_EDGE    = 2'd2,
        MODE_SHARPEN = 2'd3
    } mode_t;

endpackage

`default_nettype wire

[rtl/core/conv3x3_selectable_kernel_filter.sv]
// Top level: line-buffered 3x3 convolution with selectable kernel.
//
//  channel   dir  ports                          contents
//  -------   ---  -----------------------------  ---------------------------------
//  s_        in   s_tvalid s_tready s_tdata      pixel_in; s_tuser = pad
//  m_        out  m_tvalid m_tready m_tdata      pixel_out (9b signed); m_tlast
//  cfg_      in   cfg_wr_en cfg_index cfg_wdata  kernel_mode, frame_width, height
//
//  One pixel per clock while s_tready is high. An input transfer passes the
//  line-buffer read, the kernel adder tree and the divide stage, each registered.
//  A frame_width write recomputes row/column from the item count with a
//  bit-serial divider: input is held off after the write until it finishes.
//  Line buffers need no clearing pass; reset is synchronous, active low.
//  A 4-entry output queue absorbs m_tready stalls; s_tready drops once the
//  queue plus the items in flight would fill it.
`default_nettype none

module conv3x3_selectable_kernel_filter #(
    parameter int MAX_LINE = 1024,
    parameter int MAX_ROWS = 1024
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [7:0]                      s_tdata,   // [7:0] pixel_in
    input  wire logic                            s_tuser,   // [0] pad
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [15:0]                          m_tdata,   // [8:0] pixel_out
    output logic                                 m_tlast,   // frame_last
    input  wire logic                            cfg_wr_en,
    input  wire logic [conv3_pkg::CFG_IW-1:0]    cfg_index,
    input  wire logic [conv3_pkg::CFG_W-1:0]     cfg_wdata
);
    import conv3_pkg::*;

    localparam int WMAX  = (MAX_LINE < 2047) ? MAX_LINE : 2047;
    localparam int HMAX  = (MAX_ROWS < 2047) ? MAX_ROWS : 2047;
    localparam int CNT_W = $clog2(WMAX * (HMAX + 1) + 1);
    localparam int CW    = $clog2(WMAX);
    localparam int AW    = $clog2(MAX_LINE);
    localparam int DCW   = $clog2(CNT_W + 1);

    localparam logic [CFG_W-1:0] WMAX_C = CFG_W'(WMAX);
    localparam logic [CFG_W-1:0] HMAX_C = CFG_W'(HMAX);

    function automatic logic [CFG_W-1:0] clamp_size(input logic [CFG_W-1:0] v,
                                                    input logic [CFG_W-1:0] hi);
        logic [CFG_W-1:0] r;
        r = v;
        if (v < SIZE_MIN) r = SIZE_MIN;
        else if (v > hi) r = hi;
        return r;
    endfunction

    // configuration
    mode_t            kernel_mode_reg;
    logic [CFG_W-1:0] frame_width_reg;
    logic [CFG_W-1:0] frame_height_reg;
    logic [CFG_W-1:0] w_eff;
    logic [CFG_W-1:0] h_eff;
    logic [CFG_W:0]   hp1;

    // position counters
    logic [CNT_W-1:0] m_reg, row_reg;
    logic [CW-1:0]    col_reg;
    logic [CNT_W-1:0] m0, row0, r_out;
    logic [CW-1:0]    col0;
    logic [CW:0]      col_inc;
    logic [CFG_W-1:0] c_out;
    logic             stale, col0_zero, has_out, is_last, border, col_wrap;

    // divider
    logic             div_pend_reg, div_run_reg, busy;
    logic [DCW-1:0]   div_cnt_reg;
    logic [CNT_W-1:0] div_dq_reg, div_dq_next;
    logic [CW-1:0]    div_rem_reg, div_rem_next;
    logic [CW:0]      div_tmp;
    logic             div_ge;

    // line buffers
    logic [PIX_W-1:0] upper_mem  [MAX_LINE];
    logic [PIX_W-1:0] middle_mem [MAX_LINE];
    logic [AW-1:0]    rd_addr;
    logic [PIX_W-1:0] p_in;
    logic             s_xfer;

    // stage 1
    logic             v1_reg, has1_reg, last1_reg, border1_reg, fwd1_reg;
    logic [AW-1:0]    col1_reg;
    logic [PIX_W-1:0] p1_reg, up_rd_reg, mid_rd_reg, fwd_dat_reg, up_s1;
    logic [PIX_W-1:0] win_reg  [3][3];
    logic [PIX_W-1:0] win_next [3][3];
    logic [9:0]       s_corner, s_cross;
    logic [11:0]      s_all;
    logic [PIX_W-1:0] s_center;
    logic signed [SUM_W-1:0] sum_next;

    // stage 2
    logic             v2_reg, has2_reg, last2_reg, border2_reg;
    logic [PIX_W-1:0] center2_reg;
    logic signed [SUM_W-1:0] sum2_reg, adj_e, adj_s;
    logic [25:0]      prod;
    logic signed [10:0] sharp_v;
    logic [OUT_W-1:0] q_box, q_gauss, q_edge, q_sharp, result_next;

    // output queue
    logic [OUT_W-1:0] oq_pix_reg  [OQ_DEPTH];
    logic             oq_last_reg [OQ_DEPTH];
    logic [OQ_AW-1:0] oq_wp_reg, oq_rp_reg;
    logic [OQ_AW:0]   oq_cnt_reg, occ;
    logic             push, pop;

    assign w_eff = clamp_size(frame_width_reg, WMAX_C);
    assign h_eff = clamp_size(frame_height_reg, HMAX_C);
    assign hp1   = {1'b0, h_eff} + 1'b1;

    assign busy     = div_pend_reg | div_run_reg;
    assign occ      = oq_cnt_reg + {{OQ_AW{1'b0}}, v1_reg} + {{OQ_AW{1'b0}}, v2_reg};
    assign s_tready = !busy && (occ < (OQ_AW+1)'(OQ_DEPTH));
    assign s_xfer   = s_tvalid && s_tready;
    assign p_in     = s_tuser ? '0 : s_tdata;

    // item position
    always_comb begin
        stale = (row_reg > CNT_W'(hp1)) || ((row_reg == CNT_W'(hp1)) && (col_reg != '0));
        m0    = stale ? '0 : m_reg;
        row0  = stale ? '0 : row_reg;
        col0  = stale ? '0 : col_reg;
        col0_zero = (col0 == '0);
        has_out = (row0 >= CNT_W'(2)) || ((row0 == CNT_W'(1)) && !col0_zero);
        is_last = (row0 == CNT_W'(hp1)) && col0_zero;
        c_out = col0_zero ? (w_eff - 1'b1) : (CFG_W'(col0) - 1'b1);
        r_out = col0_zero ? (row0 - CNT_W'(2)) : (row0 - CNT_W'(1));
        border = !((r_out >= CNT_W'(1)) &&
                   ({1'b0, r_out} + (CNT_W+1)'(2) <= (CNT_W+1)'(h_eff)) &&
                   (c_out >= CFG_W'(1)) &&
                   ({1'b0, c_out} + 12'd2 <= {1'b0, w_eff}));
        col_inc  = {1'b0, col0} + 1'b1;
        col_wrap = (col_inc == (CW+1)'(w_eff));
        rd_addr  = AW'(col0);
    end

    // restoring divider: row = m / w, col = m % w
    always_comb begin
        div_tmp      = {div_rem_reg, div_dq_reg[CNT_W-1]};
        div_ge       = (div_tmp >= (CW+1)'(w_eff));
        div_rem_next = div_ge ? CW'(div_tmp - (CW+1)'(w_eff)) : div_tmp[CW-1:0];
        div_dq_next  = {div_dq_reg[CNT_W-2:0], div_ge};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kernel_mode_reg  <= MODE_BOX;
            frame_width_reg  <= SIZE_RESET;
            frame_height_reg <= SIZE_RESET;
            m_reg        <= '0;
            row_reg      <= '0;
            col_reg      <= '0;
            div_pend_reg <= 1'b0;
            div_run_reg  <= 1'b0;
            div_cnt_reg  <= '0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_KERNEL_MODE:  kernel_mode_reg  <= mode_t'(cfg_wdata[1:0]);
                    REG_FRAME_WIDTH: begin
                        frame_width_reg <= cfg_wdata;
                        div_pend_reg    <= 1'b1;
                        div_run_reg     <= 1'b0;
                    end
                    REG_FRAME_HEIGHT: frame_height_reg <= cfg_wdata;
                    default: ;
                endcase
            end
            if (div_pend_reg && !(cfg_wr_en && cfg_index == REG_FRAME_WIDTH)) begin
                div_pend_reg <= 1'b0;
                div_run_reg  <= 1'b1;
                div_cnt_reg  <= '0;
                div_dq_reg   <= m_reg;
                div_rem_reg  <= '0;
            end else if (div_run_reg && !(cfg_wr_en && cfg_index == REG_FRAME_WIDTH)) begin
                div_dq_reg  <= div_dq_next;
                div_rem_reg <= div_rem_next;
                div_cnt_reg <= div_cnt_reg + 1'b1;
                if (div_cnt_reg == DCW'(CNT_W - 1)) begin
                    div_run_reg <= 1'b0;
                    row_reg     <= div_dq_next;
                    col_reg     <= div_rem_next;
                end
            end
            if (s_xfer) begin
                if (is_last) begin
                    m_reg   <= '0;
                    row_reg <= '0;
                    col_reg <= '0;
                end else begin
                    m_reg   <= m0 + 1'b1;
                    col_reg <= col_wrap ? '0 : col_inc[CW-1:0];
                    row_reg <= col_wrap ? row0 + 1'b1 : row0;
                end
            end
        end
    end

    // line buffers: middle is read-first and rewritten at transfer,
    // upper gets the old middle value in the following cycle
    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            mid_rd_reg          <= middle_mem[rd_addr];
            middle_mem[rd_addr] <= p_in;
            up_rd_reg           <= upper_mem[rd_addr];
        end
        if (v1_reg) begin
            upper_mem[col1_reg] <= mid_rd_reg;
        end
    end

    // stage 1: window shift and kernel sum
    always_comb begin
        up_s1 = fwd1_reg ? fwd_dat_reg : up_rd_reg;
        for (int r = 0; r < 3; r++) begin
            win_next[r][0] = win_reg[r][1];
            win_next[r][1] = win_reg[r][2];
        end
        win_next[0][2] = up_s1;
        win_next[1][2] = mid_rd_reg;
        win_next[2][2] = p1_reg;
        s_corner = 10'(win_next[0][0]) + 10'(win_next[0][2]) +
                   10'(win_next[2][0]) + 10'(win_next[2][2]);
        s_cross  = 10'(win_next[0][1]) + 10'(win_next[1][0]) +
                   10'(win_next[1][2]) + 10'(win_next[2][1]);
        s_center = win_next[1][1];
        s_all    = 12'(s_corner) + 12'(s_cross) + 12'(s_center);
        case (kernel_mode_reg)
            MODE_BOX:   sum_next = {1'b0, s_all};
            MODE_GAUSS: sum_next = {3'b0, s_corner} + {2'b0, s_cross, 1'b0} +
                                   {3'b0, s_center, 2'b0};
            MODE_EDGE:  sum_next = {2'b0, s_center, 3'b0} - {4'b0, s_center, 1'b0} -
                                   {1'b0, s_all};
            MODE_SHARPEN: sum_next = {3'b0, s_center, 2'b0} + {5'b0, s_center} -
                                     {3'b0, s_cross};
            default:    sum_next = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    win_reg[r][c] <= '0;
                end
            end
        end else begin
            v1_reg <= s_xfer;
            v2_reg <= v1_reg;
            if (v1_reg) begin
                win_reg <= win_next;
            end
        end
        if (s_xfer) begin
            p1_reg      <= p_in;
            col1_reg    <= rd_addr;
            has1_reg    <= has_out;
            last1_reg   <= is_last;
            border1_reg <= border;
            fwd1_reg    <= v1_reg && (col1_reg == rd_addr);
            fwd_dat_reg <= mid_rd_reg;
        end
        if (v1_reg) begin
            sum2_reg    <= sum_next;
            center2_reg <= s_center;
            has2_reg    <= has1_reg;
            last2_reg   <= last1_reg;
            border2_reg <= border1_reg;
        end
    end

    // stage 2: divide toward zero and post scaling
    always_comb begin
        prod    = 26'(sum2_reg[11:0]) * DIV9_MUL;
        q_box   = {1'b0, prod[23:16]};
        q_gauss = {1'b0, sum2_reg[11:4]};
        adj_e   = sum2_reg + (sum2_reg[SUM_W-1] ? 13'sd127 : 13'sd0);
        q_edge  = {{3{adj_e[SUM_W-1]}}, adj_e[SUM_W-1:7]};
        adj_s   = sum2_reg + (sum2_reg[SUM_W-1] ? 13'sd7 : 13'sd0);
        sharp_v = {adj_s[SUM_W-1:3], 1'b0} + 11'sd100;
        q_sharp = (sharp_v > 11'sd255) ? 9'd255 : sharp_v[8:0];
        if (border2_reg) begin
            result_next = {1'b0, center2_reg};
        end else begin
            case (kernel_mode_reg)
                MODE_BOX:     result_next = q_box;
                MODE_GAUSS:   result_next = q_gauss;
                MODE_EDGE:    result_next = q_edge;
                MODE_SHARPEN: result_next = q_sharp;
                default:      result_next = '0;
            endcase
        end
    end

    // output queue
    assign push     = v2_reg && has2_reg;
    assign pop      = m_tvalid && m_tready;
    assign m_tvalid = (oq_cnt_reg != '0);
    assign m_tdata  = {7'b0, oq_pix_reg[oq_rp_reg]};
    assign m_tlast  = oq_last_reg[oq_rp_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            oq_wp_reg  <= '0;
            oq_rp_reg  <= '0;
            oq_cnt_reg <= '0;
        end else begin
            if (push) oq_wp_reg <= oq_wp_reg + 1'b1;
            if (pop)  oq_rp_reg <= oq_rp_reg + 1'b1;
            case ({push, pop})
                2'b10:   oq_cnt_reg <= oq_cnt_reg + 1'b1;
                2'b01:   oq_cnt_reg <= oq_cnt_reg - 1'b1;
                default: oq_cnt_reg <= oq_cnt_reg;
            endcase
        end
        if (push) begin
            oq_pix_reg[oq_wp_reg]  <= result_next;
            oq_last_reg[oq_wp_reg] <= last2_reg;
        end
    end

endmodule

`default_nettype wire

[rtl/core/conv3_checker.sv]
// Port-level checker for the 3x3 filter, bound to the top level.
`default_nettype none

module conv3_checker (
    input wire logic                         aclk,
    input wire logic                         aresetn,
    input wire logic                         s_tvalid,
    input wire logic                         s_tready,
    input wire logic                         m_tvalid,
    input wire logic                         m_tready,
    input wire logic [15:0]                  m_tdata,
    input wire logic                         m_tlast,
    input wire logic                         cfg_wr_en,
    input wire logic [conv3_pkg::CFG_IW-1:0] cfg_index
);
    import conv3_pkg::*;

    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result changed");

    a_pad_bits: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[15:9] == 7'd0)
        else $error("tdata fill bits not zero");

    a_width_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        aresetn && cfg_wr_en && cfg_index == REG_FRAME_WIDTH |=> !s_tready)
        else $error("input taken while position is recomputed");

    a_no_early_out: assert property (@(posedge aclk) disable iff (!aresetn)
        !aresetn ##1 !s_tvalid |=> !m_tvalid)
        else $error("result without any input transfer");

endmodule

bind conv3x3_selectable_kernel_filter conv3_checker u_conv3_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index)
);

`default_nettype wire
